>>> rtl/pbc_pkg.sv
// Shared types and constants for the pixel brightness/contrast block.
`default_nettype none
package pbc_pkg;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_BRIGHTNESS = 1'b0;
  localparam logic REG_CONTRAST   = 1'b1;

  // Gain divider operand widths and factors
  localparam int unsigned OPND_W = 17;
  localparam logic [OPND_W-1:0] GAIN_NUM_K = OPND_W'(259);
  localparam logic [OPND_W-1:0] GAIN_DEN_K = OPND_W'(255);

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } pix_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

>>> rtl/pbc_gain_div.sv
// Restoring divider that derives the contrast gain, one quotient bit per cycle.
`default_nettype none
module pbc_gain_div #(
  parameter int unsigned GAIN_FRACTION_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [7:0]                     contrast,
  output pbc_pkg::div_status_t                status,
  output      logic [GAIN_FRACTION_BITS+1:0]  gain
);
  import pbc_pkg::*;

  localparam int unsigned NW = OPND_W + GAIN_FRACTION_BITS;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [9:0]        c_ext;
  logic [8:0]        num_fac;
  logic [8:0]        den_fac;
  logic [OPND_W-1:0] num_base;
  logic [OPND_W-1:0] den_base;

  logic [NW-1:0]     num_r, num_nxt;
  logic [OPND_W-1:0] rem_r, rem_nxt;
  logic [OPND_W-1:0] den_r, den_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [OPND_W:0]   trial;
  logic              ge;

  assign c_ext    = {{2{contrast[7]}}, contrast};
  assign num_fac  = 9'(c_ext + 10'd255);
  assign den_fac  = 9'(10'd259 - c_ext);
  assign num_base = OPND_W'(OPND_W'(num_fac) * GAIN_NUM_K);
  assign den_base = OPND_W'(OPND_W'(den_fac) * GAIN_DEN_K);

  assign trial = {rem_r, num_r[NW-1]};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = {num_base, GAIN_FRACTION_BITS'(0)};
      rem_nxt  = '0;
      den_nxt  = den_base;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? OPND_W'(trial - {1'b0, den_r}) : trial[OPND_W-1:0];
      num_nxt = {num_r[NW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign status.busy = busy_r | done_r;
  assign status.done = done_r;
  assign gain        = num_r[GAIN_FRACTION_BITS+1:0];

endmodule
`default_nettype wire

>>> rtl/pbc_chan_map.sv
// One color channel: scale about mid-gray, round, add brightness, saturate.
`default_nettype none
module pbc_chan_map #(
  parameter int unsigned GAIN_FRACTION_BITS = 16
) (
  input  wire logic [7:0]                    pix,
  input  wire logic [GAIN_FRACTION_BITS+1:0] gain,
  input  wire logic [7:0]                    brightness,
  output      logic [7:0]                    result
);
  import pbc_pkg::*;

  localparam int unsigned PW = GAIN_FRACTION_BITS + 10;

  logic               neg;
  logic [7:0]         mag;
  logic [PW-1:0]      prod;
  logic [PW-1:0]      rnd;
  logic [9:0]         rmag;
  logic signed [11:0] sval;
  logic signed [11:0] sum;

  assign neg  = ~pix[7];
  assign mag  = neg ? 8'(8'd128 - pix) : 8'(pix - 8'd128);
  assign prod = PW'(mag) * PW'(gain);
  assign rnd  = prod + (PW'(1) << (GAIN_FRACTION_BITS - 1));
  assign rmag = rnd[GAIN_FRACTION_BITS+9:GAIN_FRACTION_BITS];
  assign sval = neg ? -$signed({2'b00, rmag}) : $signed({2'b00, rmag});
  assign sum  = sval + 12'sd128 + $signed({{4{brightness[7]}}, brightness});

  always_comb begin
    if (sum < 12'sd0) begin
      result = 8'd0;
    end else if (sum > 12'sd255) begin
      result = 8'd255;
    end else begin
      result = sum[7:0];
    end
  end

endmodule
`default_nettype wire

>>> rtl/pixel_brightness_contrast.sv
// Top level of the pixel brightness/contrast block.
// Streams one RGBA pixel per clock while not stalled: each color channel v becomes
// clamp(round(F*(v-128)) + 128 + brightness, 0, 255), alpha passes through.
// Each transaction passes an input register, then a result register, and a new
// transaction is taken every cycle while the output side keeps up. Writing
// contrast starts a bit-serial divider that recomputes the gain F; counting the
// write's access cycle, the input stalls until the new gain is loaded. Brightness
// writes take effect at once.
`default_nettype none
module pixel_brightness_contrast #(
  parameter int unsigned GAIN_FRACTION_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire pbc_pkg::pix_in_t                    in_data,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      pbc_pkg::pix_out_t                   out_data,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pbc_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [pbc_pkg::CFG_DATA_W-1:0]      pwdata,
  output      logic [pbc_pkg::CFG_DATA_W-1:0]      prdata,
  output      logic                                pready
);
  import pbc_pkg::*;

  localparam int unsigned GW = GAIN_FRACTION_BITS + 2;

  logic [7:0]    bright_r, bright_nxt;
  logic [7:0]    contrast_r, contrast_nxt;
  logic [GW-1:0] gain_r, gain_nxt;
  logic [GW-1:0] div_gain;
  div_status_t   div_st;

  logic          cfg_wr;
  logic          wr_contrast;

  pix_in_t       s1_r;
  logic          s1_valid_r, s1_valid_nxt;
  pix_out_t      out_r;
  logic          out_valid_r, out_valid_nxt;
  pix_out_t      mapped;

  logic          adv_out;
  logic          s1_ready;
  logic          in_accept;

  // Configuration
  assign pready      = 1'b1;
  assign cfg_wr      = psel & penable & pwrite;
  assign wr_contrast = cfg_wr && (paddr[2] == REG_CONTRAST);

  always_comb begin
    bright_nxt   = bright_r;
    contrast_nxt = contrast_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_BRIGHTNESS: bright_nxt   = pwdata[7:0];
        REG_CONTRAST:   contrast_nxt = pwdata[7:0];
        default:        bright_nxt   = bright_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BRIGHTNESS: prdata = CFG_DATA_W'(bright_r);
      REG_CONTRAST:   prdata = CFG_DATA_W'(contrast_r);
      default:        prdata = '0;
    endcase
  end

  pbc_gain_div #(
    .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
  ) u_gain_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (wr_contrast),
    .contrast (pwdata[7:0]),
    .status   (div_st),
    .gain     (div_gain)
  );

  assign gain_nxt = div_st.done ? div_gain : gain_r;

  // Pixel pipeline
  assign adv_out   = ~out_valid_r | ~out_stall;
  assign s1_ready  = ~s1_valid_r | adv_out;
  assign in_stall  = ~s1_ready | div_st.busy | wr_contrast;
  assign in_accept = in_valid & ~in_stall;

  assign s1_valid_nxt  = in_accept ? 1'b1 : (adv_out ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = (s1_valid_r & adv_out) ? 1'b1 : (out_valid_r & out_stall);

  pbc_chan_map #(.GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)) u_map_red (
    .pix (s1_r.in_red), .gain (gain_r), .brightness (bright_r), .result (mapped.out_red)
  );
  pbc_chan_map #(.GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)) u_map_green (
    .pix (s1_r.in_green), .gain (gain_r), .brightness (bright_r), .result (mapped.out_green)
  );
  pbc_chan_map #(.GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)) u_map_blue (
    .pix (s1_r.in_blue), .gain (gain_r), .brightness (bright_r), .result (mapped.out_blue)
  );
  assign mapped.out_alpha = s1_r.in_alpha;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r    <= '0;
      contrast_r  <= '0;
      gain_r      <= GW'(1) << GAIN_FRACTION_BITS;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bright_r    <= bright_nxt;
      contrast_r  <= contrast_nxt;
      gain_r      <= gain_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= in_data;
    end
    if (s1_valid_r && adv_out) begin
      out_r <= mapped;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_no_accept_while_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> in_stall)
    else $error("transaction accepted while gain divider busy");

  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a staged transaction");

  a_gain_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(gain_r)) |-> $past(div_st.done))
    else $error("gain changed outside divider completion");

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the pixel brightness/contrast block.
`timescale 1ns / 100ps

module testbench;
  import pbc_pkg::*;

  localparam int GAIN_FB = 16;
  localparam int HOLD_OFF_CYCLES = 160;
  localparam int DRAIN_CYCLES = 6;

  class pixel_adjust_checker;
    localparam int LEVEL_MID = 128;
    localparam int LEVEL_MAX = 255;
    localparam int CURVE_K = 259;

    int bright;
    longint gain;
    pix_out_t expected_pix[$];
    int unsigned mismatches;

    function new();
      bright = 0;
      gain = longint'(1) <<< GAIN_FB;
      mismatches = 0;
    endfunction

    function longint gain_from_contrast(int c);
      longint num;
      longint den;
      num = longint'(CURVE_K * (c + LEVEL_MAX)) <<< GAIN_FB;
      den = longint'(LEVEL_MAX * (CURVE_K - c));
      return (num / den) & ((longint'(1) <<< (GAIN_FB + 2)) - 1);
    endfunction

    function void set_reg(logic idx, logic [7:0] val);
      case (idx)
        REG_BRIGHTNESS: bright = int'($signed(val));
        REG_CONTRAST:   gain = gain_from_contrast(int'($signed(val)));
        default: ;
      endcase
    endfunction

    function logic [7:0] map_level(logic [7:0] v);
      int d;
      longint mag;
      longint r;
      longint lvl;
      d = int'(v) - LEVEL_MID;
      mag = (d < 0) ? -d : d;
      r = (mag * gain + (longint'(1) <<< (GAIN_FB - 1))) >>> GAIN_FB;
      if (d < 0) r = -r;
      lvl = r + LEVEL_MID + bright;
      if (lvl < 0) lvl = 0;
      if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
      return 8'(lvl);
    endfunction

    function void take_pixel(pix_in_t p);
      pix_out_t w;
      w.out_red   = map_level(p.in_red);
      w.out_green = map_level(p.in_green);
      w.out_blue  = map_level(p.in_blue);
      w.out_alpha = p.in_alpha;
      expected_pix.push_back(w);
    endfunction

    function void report(string what, pix_out_t want, pix_out_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                 $time, what, want.out_red, want.out_green, want.out_blue, want.out_alpha,
                 got.out_red, got.out_green, got.out_blue, got.out_alpha);
    endfunction

    function void check_pixel(pix_out_t got);
      pix_out_t want;
      if (expected_pix.size() == 0) begin
        report("unexpected transaction", '0, got);
        return;
      end
      want = expected_pix.pop_front();
      if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
          got.out_blue !== want.out_blue || got.out_alpha !== want.out_alpha)
        report("pixel mismatch", want, got);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  pix_in_t in_data;
  logic out_valid;
  logic out_stall;
  pix_out_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  pixel_adjust_checker pix_chk;
  bit send_idle_on;
  bit recv_idle_on;
  bit hold_off_req;

  pixel_brightness_contrast #(
    .GAIN_FRACTION_BITS(GAIN_FB)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("testbench failed");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) pix_chk.check_pixel(out_data);
  end

  initial begin
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (idle_len()) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic send_pixel(pix_in_t p);
    int gap;
    gap = (send_idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pix_chk.take_pixel(p);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{24{val[7]}}, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pix_chk.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pix_chk.expected_pix.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_setting();
    if ($urandom_range(0, 3) != 0) return 8'($signed($urandom_range(0, 200)) - 100);
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic run_phase(logic [7:0] b, logic [7:0] c, bit wr_b, bit wr_c, int n,
                           bit idle, bit squeeze);
    wait_drained();
    if (wr_b) write_reg(REG_BRIGHTNESS, b);
    if (wr_c) write_reg(REG_CONTRAST, c);
    send_idle_on = idle && !squeeze;
    recv_idle_on = idle;
    if (squeeze) hold_off_req = 1'b1;
    for (int i = 0; i < n; i++) send_pixel(pix_in_t'($urandom()));
    in_valid <= 1'b0;
  endtask

  pix_in_t corner_pix[8];
  logic [7:0] setting_b[7];
  logic [7:0] setting_c[7];

  initial begin
    pix_chk = new();
    corner_pix = '{
      {8'd0,   8'd255, 8'd128, 8'd0},
      {8'd255, 8'd0,   8'd127, 8'd255},
      {8'd128, 8'd128, 8'd128, 8'hAA},
      {8'd127, 8'd129, 8'd1,   8'h55},
      {8'd254, 8'd2,   8'd200, 8'd1},
      {8'h55,  8'hAA,  8'h0F,  8'hF0},
      {8'd100, 8'd156, 8'd64,  8'd192},
      {8'd255, 8'd255, 8'd255, 8'd254}
    };
    setting_b = '{8'sd127, -8'sd128, 8'sd100, -8'sd100, 8'sd0, -8'sd128, 8'sd127};
    setting_c = '{8'sd127, -8'sd128, 8'sd100, -8'sd100, 8'sd127, 8'sd127, -8'sd128};
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    hold_off_req = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity at reset, then both extremes of the settings
    for (int k = 0; k < 3; k++) begin
      wait_drained();
      if (k == 1) begin
        write_reg(REG_BRIGHTNESS, 8'sd127);
        write_reg(REG_CONTRAST, 8'sd127);
      end else if (k == 2) begin
        write_reg(REG_BRIGHTNESS, -8'sd128);
        write_reg(REG_CONTRAST, -8'sd128);
      end
      foreach (corner_pix[i]) send_pixel(corner_pix[i]);
      in_valid <= 1'b0;
    end

    foreach (setting_b[i])
      run_phase(setting_b[i], setting_c[i], 1'b1, 1'b1, 60, i % 2 == 0, i == 3);
    for (int k = 0; k < 9; k++) begin
      bit wb;
      bit wc;
      wb = $urandom_range(0, 1);
      wc = $urandom_range(0, 1);
      if (!wb && !wc) begin
        wb = 1'b1;
        wc = 1'b1;
      end
      run_phase(pick_setting(), pick_setting(), wb, wc, 70, k != 4, k == 6);
    end
    run_phase(8'sd0, 8'sd0, 1'b1, 1'b1, 40, 1'b1, 1'b0);

    wait_drained();
    if (pix_chk.mismatches == 0 && pix_chk.expected_pix.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

>>> pixel_brightness_contrast.f
rtl/pbc_pkg.sv
rtl/pbc_gain_div.sv
rtl/pbc_chan_map.sv
rtl/pixel_brightness_contrast.sv
tb/testbench.sv
